/* src/fixed_capacity_bag_table_top_assert.svh */
// Assertion macros for the bag table and its port checker
`ifndef FIXED_CAPACITY_BAG_TABLE_TOP_ASSERT_SVH
`define FIXED_CAPACITY_BAG_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FCBT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcbt check failed");

// next-cycle implication, disabled in reset
`define FCBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcbt check failed");

`endif

/* src/fcbt_pkg.sv */
// Types and constants shared by the bag table and its checker
package fcbt_pkg;

    localparam int CAPACITY_ENTRIES_DEF = 32;
    localparam int VALUE_BITS_DEF       = 32;
    localparam int ITEM_VALUE_W         = 32;
    localparam int FIELD_COUNT_W        = 6;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_COUNT  = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [ITEM_VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_COUNT_W-1:0] match_count;
        logic [1:0]               status;
        logic [FIELD_COUNT_W-1:0] occupancy;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MOVE = 3'b100
    } t_state;

endpackage

/* src/fixed_capacity_bag_table_top.sv */
// Bag table: fixed-capacity multiset held in one synchronous entry memory
// Insert, mode 3 and count/remove on an empty table: result in the cycle after accept.
// Count and remove otherwise scan in S_SCAN through the single memory read port, one
// entry a cycle; a remove that hits then goes to S_MOVE to fill the hole with the last entry.
// One item in flight at a time.
// Synchronous active-low reset empties the table; entry contents are left as they are.
module fixed_capacity_bag_table_top #(
    parameter int CAPACITY_ENTRIES = fcbt_pkg::CAPACITY_ENTRIES_DEF,
    parameter int VALUE_BITS       = fcbt_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fcbt_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output fcbt_pkg::t_out_item o_result
);
    import fcbt_pkg::*;

    localparam int AW = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;
    localparam int CW = $clog2(CAPACITY_ENTRIES + 1);
    localparam int UB = (VALUE_BITS < ITEM_VALUE_W) ? VALUE_BITS : ITEM_VALUE_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY_ENTRIES);

    logic [VALUE_BITS-1:0] mem [CAPACITY_ENTRIES];

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_hits, n_hits;
    logic [AW-1:0]         r_idx, n_idx;
    logic [1:0]            r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_strobe, n_strobe;
    t_out_item             r_result, n_result;
    logic [VALUE_BITS-1:0] r_rd_data;

    logic                  s_acc, s_hit, s_last, s_we;
    logic [AW-1:0]         s_wa, s_ra;
    logic [VALUE_BITS-1:0] s_wd, s_val_in;
    logic [CW-1:0]         s_hits_sum;

    assign s_acc      = start && (r_state == S_IDLE);
    assign s_val_in   = VALUE_BITS'(i_item.item_value[UB-1:0]);
    assign s_hit      = (r_rd_data == r_val);
    assign s_last     = ((CW'(r_idx) + CW'(1)) == r_count);
    assign s_hits_sum = r_hits + CW'(s_hit);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_hits   = r_hits;
        n_idx    = r_idx;
        n_mode   = r_mode;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_result = r_result;
        s_we     = 1'b0;
        s_wa     = r_count[AW-1:0];
        s_wd     = s_val_in;
        s_ra     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_mode = i_item.mode;
                    n_val  = s_val_in;
                    n_idx  = '0;
                    n_hits = '0;
                    n_result.match_count = '0;
                    n_result.status      = STAT_DONE;
                    n_result.occupancy   = FIELD_COUNT_W'(r_count);
                    priority if (i_item.mode == MODE_INSERT) begin
                        n_strobe = 1'b1;
                        if (r_count == CAP) begin
                            n_result.status = STAT_FULL;
                        end else begin
                            s_we               = 1'b1;
                            n_count            = r_count + CW'(1);
                            n_result.occupancy = FIELD_COUNT_W'(r_count + CW'(1));
                        end
                    end else if ((i_item.mode == MODE_COUNT || i_item.mode == MODE_REMOVE)
                                 && r_count == '0) begin
                        n_strobe = 1'b1;
                        if (i_item.mode == MODE_REMOVE) begin
                            n_result.status = STAT_ABSENT;
                        end
                    end else if (i_item.mode == MODE_COUNT || i_item.mode == MODE_REMOVE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_strobe = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                s_ra  = s_last ? '0 : r_idx + AW'(1);
                n_idx = r_idx + AW'(1);
                n_result.match_count = '0;
                n_result.status      = STAT_DONE;
                n_result.occupancy   = FIELD_COUNT_W'(r_count);
                if (r_mode == MODE_REMOVE) begin
                    if (s_hit) begin
                        // fetch the last entry to fill the hole
                        s_ra    = AW'(r_count - CW'(1));
                        n_idx   = r_idx;
                        n_state = S_MOVE;
                    end else if (s_last) begin
                        n_strobe        = 1'b1;
                        n_result.status = STAT_ABSENT;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_hits = s_hits_sum;
                    if (s_last) begin
                        n_strobe             = 1'b1;
                        n_result.match_count = FIELD_COUNT_W'(s_hits_sum);
                        n_state              = S_IDLE;
                    end
                end
            end
            S_MOVE: begin
                s_we     = 1'b1;
                s_wa     = r_idx;
                s_wd     = r_rd_data;
                n_count  = r_count - CW'(1);
                n_strobe = 1'b1;
                n_result.match_count = '0;
                n_result.status      = STAT_DONE;
                n_result.occupancy   = FIELD_COUNT_W'(r_count - CW'(1));
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem[s_wa] <= s_wd;
        end
        r_rd_data <= mem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hits   <= n_hits;
        r_idx    <= n_idx;
        r_mode   <= n_mode;
        r_val    <= n_val;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* src/fcbt_checker.sv */
// Port-level checker for the bag table, bound to the top level
`include "fixed_capacity_bag_table_top_assert.svh"

module fcbt_checker #(
    parameter int CAPACITY_ENTRIES = fcbt_pkg::CAPACITY_ENTRIES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input fcbt_pkg::t_out_item o_result
);
    import fcbt_pkg::*;

    `FCBT_ASSERT_NEXT(a_accept_reacts, start && !busy, busy || o_strobe)
    `FCBT_ASSERT_NOW(a_status_code, o_strobe, o_result.status != 2'd3)
    `FCBT_ASSERT_NOW(a_full_occ, o_strobe && o_result.status == STAT_FULL,
                     o_result.occupancy == FIELD_COUNT_W'(CAPACITY_ENTRIES))
    `FCBT_ASSERT_NOW(a_hits_done, o_strobe && o_result.match_count != '0,
                     o_result.status == STAT_DONE)

endmodule

bind fixed_capacity_bag_table_top fcbt_checker #(
    .CAPACITY_ENTRIES(CAPACITY_ENTRIES)
) u_fcbt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

/* dv/fixed_capacity_bag_table_top_tb.sv */
// Self-checking testbench for the fixed-capacity bag table: insert, count and remove items
`timescale 1ns / 1ps

module fixed_capacity_bag_table_top_tb;
    import fcbt_pkg::*;

    localparam int          BAG_DEPTH   = CAPACITY_ENTRIES_DEF;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int          SETTLE_CYC  = BAG_DEPTH + 8;
    localparam int          STALL_LIMIT = 4000;
    localparam int          RAND_ITEMS  = 2000;

    typedef struct {
        t_in_item item;
        int       gap_after;
        bit       drain_first;
    } t_pending;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_strobe;
    t_out_item o_result;

    t_pending  pend_q[$];
    t_out_item bag_expect_q[$];

    logic [31:0] bag_mem [BAG_DEPTH];
    int          bag_fill = 0;

    bit          taken = 1'b0;
    int          gap_cnt = 0;
    int          stall_cyc = 0;
    int          err_cnt = 0;
    int          n_ins = 0, n_full = 0, n_cnt = 0, n_rem = 0, n_absent = 0;
    int          n_ignored = 0, n_checked = 0, peak_fill = 0;

    fixed_capacity_bag_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // apply one item to the shadow bag, return the result it should give
    function automatic t_out_item bag_apply(input t_in_item it);
        t_out_item r;
        int        pos;
        r = '0;
        case (it.mode)
            MODE_INSERT: begin
                n_ins++;
                if (bag_fill >= BAG_DEPTH) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    bag_mem[bag_fill] = it.item_value;
                    bag_fill++;
                end
            end
            MODE_COUNT: begin
                n_cnt++;
                for (int i = 0; i < bag_fill; i++)
                    if (bag_mem[i] == it.item_value) r.match_count++;
            end
            MODE_REMOVE: begin
                n_rem++;
                pos = -1;
                for (int i = 0; i < bag_fill; i++)
                    if (pos < 0 && bag_mem[i] == it.item_value) pos = i;
                if (pos < 0) begin
                    r.status = STAT_ABSENT;
                    n_absent++;
                end else begin
                    bag_fill--;
                    bag_mem[pos] = bag_mem[bag_fill];
                end
            end
            default: n_ignored++;
        endcase
        r.occupancy = bag_fill[FIELD_COUNT_W-1:0];
        if (bag_fill > peak_fill) peak_fill = bag_fill;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_item(input logic [1:0] mode, input logic [31:0] val,
                              input bit drain, input bit no_gaps);
        t_pending p;
        p.item.mode       = mode;
        p.item.item_value = val;
        p.gap_after       = no_gaps ? 0 : pick_gap();
        p.drain_first     = drain;
        pend_q.push_back(p);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                start   <= 1'b0;
            end else if (pend_q.size() == 0) begin
                start <= 1'b0;
            end else if (pend_q[0].drain_first && bag_expect_q.size() != 0) begin
                start <= 1'b0;
            end else begin
                i_item  <= pend_q[0].item;
                gap_cnt <= pend_q[0].gap_after;
                start   <= 1'b1;
                void'(pend_q.pop_front());
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            if (o_strobe) begin
                if (bag_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, occupancy", o_result.occupancy, -1);
                end else begin
                    want = bag_expect_q.pop_front();
                    n_checked++;
                    if (o_result.match_count !== want.match_count)
                        report_mismatch("match_count", o_result.match_count, want.match_count);
                    if (o_result.status !== want.status)
                        report_mismatch("status", o_result.status, want.status);
                    if (o_result.occupancy !== want.occupancy)
                        report_mismatch("occupancy", o_result.occupancy, want.occupancy);
                end
            end
            if (start && !busy) begin
                bag_expect_q.push_back(bag_apply(i_item));
                taken <= 1'b1;
            end else begin
                taken <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cyc <= 0;
        end else if (stall_cyc >= STALL_LIMIT) begin
            $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("[fixed_capacity_bag_table_top] ERROR");
            $finish;
        end else begin
            stall_cyc <= stall_cyc + 1;
        end
    end

    initial begin
        logic [31:0] pool [8];
        t_phase      ph;
        int          ph_len;
        int          r;
        int          n_rand;
        bit          quiet;
        logic [1:0]  mode;
        logic [31:0] val;

        // directed: empty table, extremes, duplicates, first/last removal, unused mode
        queue_item(MODE_COUNT,  32'h0000_0000, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'h0000_0005, 1'b0, 1'b0);
        queue_item(MODE_UNUSED, 32'hDEAD_BEEF, 1'b0, 1'b0);
        queue_item(MODE_INSERT, 32'h0000_0000, 1'b0, 1'b0);
        queue_item(MODE_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_INSERT, 32'h1234_5678, 1'b0, 1'b0);
        queue_item(MODE_COUNT,  32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_COUNT,  32'h0000_0000, 1'b0, 1'b0);
        queue_item(MODE_COUNT,  32'h0000_0001, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'h0000_0055, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'h0000_0000, 1'b0, 1'b0);
        queue_item(MODE_COUNT,  32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_UNUSED, 32'h0000_0000, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'h1234_5678, 1'b0, 1'b0);
        queue_item(MODE_COUNT,  32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_INSERT, 32'hA5A5_A5A5, 1'b0, 1'b0);
        queue_item(MODE_INSERT, 32'h5A5A_5A5A, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'h5A5A_5A5A, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'hA5A5_A5A5, 1'b0, 1'b0);
        queue_item(MODE_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(MODE_COUNT,  32'hFFFF_FFFF, 1'b0, 1'b0);

        // random phases: fill to capacity and beyond, drain, and mixed traffic
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            ph    = t_phase'($urandom_range(0, 2));
            quiet = ($urandom_range(0, 3) == 0);
            ph_len = (ph == PH_MIX) ? 30 : 50;
            foreach (pool[k]) begin
                r = $urandom_range(0, 9);
                pool[k] = (r == 0) ? 32'h0000_0000 :
                          (r == 1) ? 32'hFFFF_FFFF : $urandom();
            end
            for (int j = 0; j < ph_len; j++) begin
                r = $urandom_range(0, 99);
                case (ph)
                    PH_FILL:  mode = (r < 85) ? MODE_INSERT : (r < 95) ? MODE_COUNT : MODE_REMOVE;
                    PH_DRAIN: mode = (r < 80) ? MODE_REMOVE : (r < 92) ? MODE_COUNT : MODE_INSERT;
                    default:  mode = (r < 32) ? MODE_INSERT : (r < 64) ? MODE_COUNT :
                                     (r < 97) ? MODE_REMOVE : MODE_UNUSED;
                endcase
                val = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
                queue_item(mode, val, (j == 0) && (n_rand == 0 || $urandom_range(0, 2) == 0),
                           quiet);
                if (mode != MODE_UNUSED) n_rand++;
            end
        end

        while (pend_q.size() != 0 || start || bag_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("run covered %0d inserts (%0d refused when full), %0d counts, %0d removes",
                 n_ins, n_full, n_cnt, n_rem);
        $display("%0d removes found nothing, %0d unused-mode items, peak occupancy %0d, %0d results checked",
                 n_absent, n_ignored, peak_fill, n_checked);
        if (err_cnt == 0) begin
            $display("[fixed_capacity_bag_table_top] OK");
        end else begin
            $display("[fixed_capacity_bag_table_top] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/fcbt_pkg.sv
src/fixed_capacity_bag_table_top.sv
src/fcbt_checker.sv
dv/fixed_capacity_bag_table_top_tb.sv
